### src/assert_macros.svh
// Assertion macros used by gesture_dimmer_controller_top.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property check on a clock, disabled while reset is high
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition that must never hold on a clock edge
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### src/gdc_pkg.sv
// Types and constants for the gesture dimmer controller.
// No dependencies; used by gesture_dimmer_controller_top.
package gdc_pkg;

   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 16;
   localparam int SHIFT    = 6;
   localparam int LEVEL_W  = SUM_W - SHIFT;
   localparam int DUTY_W   = 16;
   localparam int DELAY_W  = 11;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_SENSE_TH  = 3'd0;
   localparam logic [2:0] REG_TRACK_TH  = 3'd1;
   localparam logic [2:0] REG_DEBOUNCE  = 3'd2;
   localparam logic [2:0] REG_START_HLD = 3'd3;
   localparam logic [2:0] REG_END_HLD   = 3'd4;
   localparam logic [2:0] REG_MIN_CHG   = 3'd5;

   // register reset values
   localparam logic [8:0]  RST_SENSE_TH  = 9'd150;
   localparam logic [8:0]  RST_TRACK_TH  = 9'd230;
   localparam logic [7:0]  RST_DEBOUNCE  = 8'd30;
   localparam logic [7:0]  RST_START_HLD = 8'd180;
   localparam logic [7:0]  RST_END_HLD   = 8'd210;
   localparam logic [15:0] RST_MIN_CHG   = 16'd15;

   localparam logic [DUTY_W-1:0] DUTY_FULL     = 16'hFFFF;
   localparam logic [DUTY_W-1:0] REMEMBER_INIT = 16'd4095;
   localparam logic [DUTY_W-1:0] HAND_FLOOR    = 16'd8;
   localparam logic [LEVEL_W-1:0] TRACK_SPAN   = 10'd255;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_0;
      logic [SAMPLE_W-1:0] sample_1;
      logic [SAMPLE_W-1:0] sample_2;
      logic [SAMPLE_W-1:0] sample_3;
      logic [SAMPLE_W-1:0] sample_4;
   } gdc_req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]  pulse_width;
      logic               duty_changed;
      logic [DELAY_W-1:0] step_delay;
      logic               lamp_on;
      logic               tracking_mode;
   } gdc_rsp_type;

endpackage

### src/gesture_dimmer_controller_top.sv
// Gesture dimmer controller: two-stage datapath with APB-style registers.
// Depends on gdc_pkg and assert_macros.svh.
//
// Usage:
//   One request per sensor tick on req_* carries five 12-bit samples. Each
//   request yields exactly one response on rsp_* with the PWM compare
//   value, a changed flag, the spin delay, the lamp and tracking flags.
//   Stage one registers the sensed level (sample sum >> 6); stage two runs
//   the gesture and ramp logic against the state registers and loads the
//   response register. rsp_valid rises when stage two loads the response
//   register, which can wait while a stalled response is held.
//   Throughput is one request per cycle while rsp_stall is low, bounded
//   only by the state update loop in stage two.
//   When rsp_stall is high, the response register holds and stage one can
//   still take one more request; req_stall rises only when both are full.
//   Registers sit at byte addresses 4*i on psel/penable/pwrite/paddr/pwdata;
//   writes land on the access cycle, pready is always high, reads return
//   the register value. Write registers only while the block is idle.
//   Synchronous active-high reset empties both stages, loads the register
//   defaults and clears the dimmer state (remembered level 4095).
//
module gesture_dimmer_controller_top
   import gdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gdc_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gdc_rsp_type       rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

`include "assert_macros.svh"

   // ---------------- configuration registers ----------------
   logic [8:0]  sense_th_ff, track_th_ff;
   logic [7:0]  debounce_len_ff, start_hold_ff, end_hold_ff;
   logic [15:0] min_change_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         sense_th_ff     <= RST_SENSE_TH;
         track_th_ff     <= RST_TRACK_TH;
         debounce_len_ff <= RST_DEBOUNCE;
         start_hold_ff   <= RST_START_HLD;
         end_hold_ff     <= RST_END_HLD;
         min_change_ff   <= RST_MIN_CHG;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SENSE_TH:  sense_th_ff     <= pwdata[8:0];
            REG_TRACK_TH:  track_th_ff     <= pwdata[8:0];
            REG_DEBOUNCE:  debounce_len_ff <= pwdata[7:0];
            REG_START_HLD: start_hold_ff   <= pwdata[7:0];
            REG_END_HLD:   end_hold_ff     <= pwdata[7:0];
            REG_MIN_CHG:   min_change_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (csr_idx)
         REG_SENSE_TH:  prdata = {23'd0, sense_th_ff};
         REG_TRACK_TH:  prdata = {23'd0, track_th_ff};
         REG_DEBOUNCE:  prdata = {24'd0, debounce_len_ff};
         REG_START_HLD: prdata = {24'd0, start_hold_ff};
         REG_END_HLD:   prdata = {24'd0, end_hold_ff};
         REG_MIN_CHG:   prdata = {16'd0, min_change_ff};
         default:       prdata = '0;
      endcase
   end

   // ---------------- pipeline handshake ----------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready, s1_ready, req_take, s1_adv;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_stall = !s1_ready;
   assign req_take  = req_valid && s1_ready;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- stage one: sensed level ----------------
   logic [SUM_W-1:0]   sample_sum;
   logic [LEVEL_W-1:0] level_ff, level_in;

   assign sample_sum = SUM_W'(req_data.sample_0) + SUM_W'(req_data.sample_1)
                     + SUM_W'(req_data.sample_2) + SUM_W'(req_data.sample_3)
                     + SUM_W'(req_data.sample_4);
   assign level_in   = sample_sum[SUM_W-1:SHIFT];

   always_ff @(posedge clock) begin
      if (req_take) begin
         level_ff <= level_in;
      end
   end

   // ---------------- stage two: gesture state and ramp ----------------
   logic [DUTY_W-1:0] duty_ff, duty_in, target_ff, target_in;
   logic [DUTY_W-1:0] remember_ff, remember_in;
   logic              lamp_ff, lamp_in, track_ff, track_in;
   logic [7:0]        hold_ff, hold_in, debounce_ff, debounce_in;

   logic               present;
   logic [LEVEL_W-1:0] track_lo, track_hi, excess;
   logic [DUTY_W-1:0]  hand, hand_floor, hand_diff, ramp_diff;
   logic [DUTY_W:0]    avg_sum;
   logic [7:0]         hold_inc;
   logic               changed;
   logic [DUTY_W-1:0]  delay_full;
   gdc_rsp_type        rsp_in;
   gdc_rsp_type        rsp_ff;

   assign present  = level_ff > LEVEL_W'(sense_th_ff);
   assign track_lo = LEVEL_W'(track_th_ff);
   assign track_hi = track_lo + TRACK_SPAN;
   assign excess   = level_ff - track_lo;
   assign hold_inc = hold_ff + 8'd1;

   // hand distance to brightness
   always_comb begin
      if (level_ff > track_hi) begin
         hand = '0;
      end else if (level_ff < track_lo) begin
         hand = DUTY_FULL;
      end else begin
         hand = DUTY_FULL - DUTY_W'(excess);
      end
   end

   assign hand_floor = (hand > HAND_FLOOR) ? hand : HAND_FLOOR;
   assign hand_diff  = (target_ff > hand) ? (target_ff - hand) : (hand - target_ff);
   assign avg_sum    = {1'b0, target_ff} + {1'b0, hand_floor};

   // gesture decision
   always_comb begin
      target_in   = target_ff;
      remember_in = remember_ff;
      lamp_in     = lamp_ff;
      track_in    = track_ff;
      hold_in     = hold_ff;
      debounce_in = debounce_ff;
      if (debounce_ff != 8'd0) begin
         debounce_in = debounce_ff - 8'd1;
      end else if (track_ff) begin
         if (present) begin
            if (hand_diff > min_change_ff || !lamp_ff) begin
               target_in = avg_sum[DUTY_W:1];
               lamp_in   = 1'b1;
            end
            hold_in = '0;
         end else begin
            target_in   = duty_ff;
            remember_in = duty_ff;
            hold_in     = hold_inc;
            if (hold_inc == end_hold_ff) begin
               track_in = 1'b0;
               hold_in  = '0;
            end
         end
      end else begin
         if (present) begin
            hold_in = hold_inc;
            if (hold_inc == start_hold_ff) begin
               track_in = 1'b1;
               hold_in  = '0;
            end
         end else begin
            // tap released: toggle the lamp
            if (hold_ff != 8'd0) begin
               lamp_in     = !lamp_ff;
               target_in   = lamp_ff ? '0 : remember_ff;
               debounce_in = debounce_len_ff;
            end
            hold_in = '0;
         end
      end
   end

   // one ramp step toward the new target
   always_comb begin
      duty_in = duty_ff;
      changed = 1'b0;
      if (duty_ff > target_in) begin
         duty_in = duty_ff - 16'd1;
         changed = 1'b1;
      end else if (duty_ff < target_in) begin
         duty_in = duty_ff + 16'd1;
         changed = 1'b1;
      end
   end

   assign ramp_diff  = (target_in > duty_in) ? (target_in - duty_in) : (duty_in - target_in);
   assign delay_full = DUTY_FULL - ramp_diff;

   always_comb begin
      rsp_in.pulse_width   = duty_in;
      rsp_in.duty_changed  = changed;
      rsp_in.step_delay    = changed ? delay_full[DUTY_W-1:5] : '0;
      rsp_in.lamp_on       = lamp_in;
      rsp_in.tracking_mode = track_in;
   end

   // state registers advance with stage two
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff     <= '0;
         target_ff   <= '0;
         remember_ff <= REMEMBER_INIT;
         lamp_ff     <= 1'b0;
         track_ff    <= 1'b0;
         hold_ff     <= '0;
         debounce_ff <= '0;
      end else if (s1_adv) begin
         duty_ff     <= duty_in;
         target_ff   <= target_in;
         remember_ff <= remember_in;
         lamp_ff     <= lamp_in;
         track_ff    <= track_in;
         hold_ff     <= hold_in;
         debounce_ff <= debounce_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ---------------- assertions ----------------
   `ASSERT_PROP(a_state_hold, clock, reset, !s1_adv |=> duty_ff == $past(duty_ff))
   `ASSERT_PROP(a_delay_zero, clock, reset,
      rsp_valid && !rsp_data.duty_changed |-> rsp_data.step_delay == '0)
   `ASSERT_NEVER(a_debounce_track, clock, reset, debounce_ff != 8'd0 && track_ff)
   `ASSERT_PROP(a_stall_full, clock, reset, req_stall |-> s1_valid_ff && rsp_valid_ff)
   `ASSERT_PROP(a_track_hold, clock, reset, $rose(track_ff) |-> hold_ff == 8'd0)

endmodule

### test/tb_gesture_dimmer_controller_top.sv
// Self-checking testbench for gesture_dimmer_controller_top: directed ticks, then gesture traffic.
// Depends on gdc_pkg and the RTL only; each tick is scored against an in-line prediction or a typed value.
module tb_gesture_dimmer_controller_top;
   import gdc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SAMPLE_MAX    = 4095;
   localparam int unsigned MAX_LEVEL     = (5 * SAMPLE_MAX) >> SHIFT;
   localparam int unsigned DELAY_SHIFT   = 5;
   localparam int unsigned WATCHDOG_LIMIT = 400;
   localparam int unsigned TAIL_CYCLES   = 10;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
   localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

   typedef enum {TICK_PRESENT, TICK_ABSENT, TICK_NOISE} tick_type;

   // one register setting plus how much gesture traffic to run under it
   typedef struct packed {
      logic [8:0]  sense;
      logic [8:0]  track;
      logic [7:0]  debounce;
      logic [7:0]  start_hold;
      logic [7:0]  end_hold;
      logic [15:0] min_chg;
      logic [15:0] quota;
      logic        lead_hold;
   } setting_type;

   typedef struct packed {
      logic        reconfig;
      gdc_req_type req;
      logic        typed;
      gdc_rsp_type rsp;
   } directed_row_type;

   localparam gdc_req_type QUIET     = '{12'h000, 12'h000, 12'h000, 12'h000, 12'h000};
   localparam gdc_req_type ALL_FULL  = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
   localparam gdc_req_type ALT_HI    = '{12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA};
   localparam gdc_req_type ALT_LO    = '{12'h555, 12'h555, 12'h555, 12'h555, 12'h555};
   localparam gdc_req_type MID_HEAD  = '{12'hFFF, 12'h901, 12'h000, 12'h000, 12'h000};
   localparam gdc_req_type MID_TAIL  = '{12'h000, 12'h000, 12'h000, 12'h901, 12'hFFF};
   localparam gdc_req_type NEAR      = '{12'hA00, 12'h000, 12'h000, 12'h000, 12'h000};
   localparam gdc_req_type FOUR_FULL = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000};
   localparam gdc_req_type ONE_FULL  = '{12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000};
   localparam gdc_rsp_type DARK      = '0;
   // first step up from off toward the remembered level of 4095
   localparam gdc_rsp_type FIRST_UP  = '{16'd1, 1'b1, 11'd1920, 1'b1, 1'b0};

   // settings for the directed part after the first three ticks: short holds, short debounce
   localparam setting_type DIRECTED_SETUP =
      '{9'd20, 9'd60, 8'd1, 8'd2, 8'd2, 16'd0, 16'd0, 1'b0};

   localparam directed_row_type DIRECTED_PLAN [16] = '{
      '{1'b0, QUIET,     1'b1, DARK},      // idle after reset
      '{1'b0, ALL_FULL,  1'b1, DARK},      // largest sum, presence starts
      '{1'b0, ALT_HI,    1'b1, DARK},      // presence continues
      '{1'b1, QUIET,     1'b1, FIRST_UP},  // short presence ends: lamp toggles on
      '{1'b0, ALT_LO,    1'b0, DARK},      // swallowed by debounce
      '{1'b0, MID_HEAD,  1'b0, DARK},
      '{1'b0, MID_TAIL,  1'b0, DARK},      // hold reached: tracking
      '{1'b0, NEAR,      1'b0, DARK},      // hand below track threshold: full
      '{1'b0, FOUR_FULL, 1'b0, DARK},      // hand inside the falling span
      '{1'b0, ALL_FULL,  1'b0, DARK},      // hand beyond the span: floor value
      '{1'b0, ONE_FULL,  1'b0, DARK},
      '{1'b0, QUIET,     1'b0, DARK},      // absence while tracking
      '{1'b0, QUIET,     1'b0, DARK},      // absence hold reached: tracking ends
      '{1'b0, MID_HEAD,  1'b0, DARK},
      '{1'b0, QUIET,     1'b0, DARK},      // toggles lamp off
      '{1'b0, QUIET,     1'b0, DARK}
   };

   localparam setting_type RANDOM_PHASES [5] = '{
      '{9'd150, 9'd230, 8'd30,  8'd180, 8'd210, 16'd15,    16'd90,  1'b0},
      '{9'd20,  9'd60,  8'd0,   8'd3,   8'd4,   16'd0,     16'd150, 1'b0},
      '{9'd511, 9'd511, 8'd255, 8'd255, 8'd255, 16'd65535, 16'd30,  1'b0},
      '{9'd0,   9'd0,   8'd0,   8'd1,   8'd1,   16'd0,     16'd70,  1'b0},
      '{9'd100, 9'd150, 8'd5,   8'd0,   8'd0,   16'd100,   16'd540, 1'b1}
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   gdc_req_type       req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   gdc_rsp_type       rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // shadow registers and dimmer state of the predictor
   logic [8:0]  cfg_sense, cfg_track;
   logic [7:0]  cfg_debounce, cfg_start, cfg_end;
   logic [15:0] cfg_min;
   int unsigned duty_now, target_now, remembered_now;
   logic        lamp_now, tracking_now;
   logic [7:0]  hold_now, debounce_left;

   gdc_rsp_type dimmer_outputs_due [$];
   int unsigned fault_count;
   int unsigned requests_sent;
   int unsigned outputs_checked;
   int unsigned settings_used;
   int unsigned phase_sent;
   int unsigned idle_cycles;
   bit          feed_eager;
   bit          drain_eager;

   gesture_dimmer_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic record_fault(string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("[%0t] check failed: %s", $realtime, msg);
      end
   endtask

   // register defaults and cleared dimmer state
   function automatic void dimmer_reset();
      cfg_sense      = RST_SENSE_TH;
      cfg_track      = RST_TRACK_TH;
      cfg_debounce   = RST_DEBOUNCE;
      cfg_start      = RST_START_HLD;
      cfg_end        = RST_END_HLD;
      cfg_min        = RST_MIN_CHG;
      duty_now       = 0;
      target_now     = 0;
      remembered_now = REMEMBER_INIT;
      lamp_now       = 1'b0;
      tracking_now   = 1'b0;
      hold_now       = 8'd0;
      debounce_left  = 8'd0;
   endfunction

   // one sensor tick: gesture logic, then one ramp step of the duty
   function automatic gdc_rsp_type dimmer_step(gdc_req_type r);
      int unsigned total, lvl, hand, spread;
      gdc_rsp_type o;
      total = 32'(r.sample_0) + 32'(r.sample_1) + 32'(r.sample_2)
            + 32'(r.sample_3) + 32'(r.sample_4);
      lvl = (total & 32'hFFFF) >> SHIFT;
      o = '0;
      if (debounce_left != 8'd0) begin
         debounce_left = debounce_left - 8'd1;
      end else if (tracking_now) begin
         if (lvl > cfg_sense) begin
            if (lvl > 32'(cfg_track) + 32'(TRACK_SPAN)) begin
               hand = 0;
            end else if (lvl < cfg_track) begin
               hand = DUTY_FULL;
            end else begin
               hand = DUTY_FULL - (lvl - cfg_track);
            end
            spread = target_now > hand ? target_now - hand : hand - target_now;
            if (spread > cfg_min || !lamp_now) begin
               target_now = (target_now + (hand > HAND_FLOOR ? hand : HAND_FLOOR)) >> 1;
               lamp_now = 1'b1;
            end
            hold_now = 8'd0;
         end else begin
            target_now = duty_now;
            remembered_now = duty_now;
            hold_now = hold_now + 8'd1;
            if (hold_now == cfg_end) begin
               tracking_now = 1'b0;
               hold_now = 8'd0;
            end
         end
      end else if (lvl > cfg_sense) begin
         hold_now = hold_now + 8'd1;
         if (hold_now == cfg_start) begin
            tracking_now = 1'b1;
            hold_now = 8'd0;
         end
      end else begin
         if (hold_now != 8'd0) begin
            lamp_now = !lamp_now;
            target_now = lamp_now ? remembered_now : 0;
            debounce_left = cfg_debounce;
         end
         hold_now = 8'd0;
      end

      // ramp toward the target
      if (duty_now != target_now) begin
         duty_now = duty_now > target_now ? duty_now - 1 : duty_now + 1;
         spread = target_now > duty_now ? target_now - duty_now : duty_now - target_now;
         o.duty_changed = 1'b1;
         o.step_delay = DELAY_W'((32'(DUTY_FULL) - spread) >> DELAY_SHIFT);
      end
      o.pulse_width = DUTY_W'(duty_now);
      o.lamp_on = lamp_now;
      o.tracking_mode = tracking_now;
      return o;
   endfunction

   // drive one request with a random lead-in gap, then log its expected output
   task automatic push_request(gdc_req_type d, bit has_typed, gdc_rsp_type typed);
      int unsigned gap;
      gdc_rsp_type predicted;
      if ($urandom_range(0, 39) == 0) feed_eager = !feed_eager;
      gap = feed_eager ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (req_stall);
      predicted = dimmer_step(d);
      dimmer_outputs_due.push_back(has_typed ? typed : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   // APB write, then read back the written register if it is implemented
   task automatic write_register(logic [2:0] idx, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] stored;
      stored = '0;
      case (idx)
         REG_SENSE_TH: begin
            cfg_sense = value[8:0];
            stored = DATA_W'(cfg_sense);
         end
         REG_TRACK_TH: begin
            cfg_track = value[8:0];
            stored = DATA_W'(cfg_track);
         end
         REG_DEBOUNCE: begin
            cfg_debounce = value[7:0];
            stored = DATA_W'(cfg_debounce);
         end
         REG_START_HLD: begin
            cfg_start = value[7:0];
            stored = DATA_W'(cfg_start);
         end
         REG_END_HLD: begin
            cfg_end = value[7:0];
            stored = DATA_W'(cfg_end);
         end
         REG_MIN_CHG: begin
            cfg_min = value[15:0];
            stored = DATA_W'(cfg_min);
         end
         default: ;
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (idx <= REG_MIN_CHG) begin
         pwrite <= 1'b0;
         penable <= 1'b0;
         @(negedge clock);
         penable <= 1'b1;
         @(posedge clock);
         if (prdata !== stored) begin
            record_fault($sformatf("register %0d read %0h, wrote %0h", idx, prdata, stored));
         end
         @(negedge clock);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // let every outstanding request come back before touching registers
   task automatic settle_then_apply(setting_type s);
      req_valid <= 1'b0;
      while (dimmer_outputs_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_register(REG_SENSE_TH, DATA_W'(s.sense));
      write_register(REG_TRACK_TH, DATA_W'(s.track));
      write_register(REG_DEBOUNCE, DATA_W'(s.debounce));
      write_register(REG_START_HLD, DATA_W'(s.start_hold));
      write_register(REG_END_HLD, DATA_W'(s.end_hold));
      write_register(REG_MIN_CHG, DATA_W'(s.min_chg));
      settings_used++;
   endtask

   // one tick with samples summing to a level on the wanted side of the threshold, or random samples for noise
   task automatic send_tick(tick_type kind);
      gdc_req_type d;
      int unsigned lvl, total, lo, hi;
      logic [SAMPLE_W-1:0] part [5];
      if (kind == TICK_PRESENT && cfg_sense >= MAX_LEVEL) kind = TICK_NOISE;
      if (kind == TICK_NOISE) begin
         foreach (part[k]) part[k] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      end else begin
         if (kind == TICK_PRESENT) begin
            lvl = $urandom_range(MAX_LEVEL, 32'(cfg_sense) + 1);
         end else begin
            lvl = $urandom_range(cfg_sense < MAX_LEVEL ? cfg_sense : MAX_LEVEL, 0);
         end
         total = (lvl << SHIFT) + $urandom_range(0, (1 << SHIFT) - 1);
         if (total > 5 * SAMPLE_MAX) total = 5 * SAMPLE_MAX;
         for (int k = 0; k < 4; k++) begin
            lo = total > SAMPLE_MAX * (4 - k) ? total - SAMPLE_MAX * (4 - k) : 0;
            hi = total < SAMPLE_MAX ? total : SAMPLE_MAX;
            part[k] = SAMPLE_W'($urandom_range(hi, lo));
            total -= part[k];
         end
         part[4] = SAMPLE_W'(total);
      end
      d = '{part[0], part[1], part[2], part[3], part[4]};
      push_request(d, 1'b0, DARK);
   endtask

   task automatic emit(tick_type kind, int unsigned count, int unsigned quota);
      repeat (count) begin
         if (phase_sent < quota) begin
            send_tick(kind);
            phase_sent++;
         end
      end
   endtask

   // a hold register of zero only matches after the counter wraps
   function automatic int unsigned hold_span(logic [7:0] ticks);
      return ticks == 8'd0 ? 256 : ticks;
   endfunction

   // gesture traffic: taps, long holds into and out of tracking, pauses, noise, flicker
   task automatic play_gestures(setting_type s);
      int unsigned pick;
      bit first;
      phase_sent = 0;
      first = s.lead_hold;
      while (phase_sent < s.quota) begin
         pick = first ? 3 : $urandom_range(0, 9);
         first = 1'b0;
         if (pick < 3) begin
            emit(TICK_PRESENT, $urandom_range(1, 3), s.quota);
            emit(TICK_ABSENT, $urandom_range(1, 3), s.quota);
         end else if (pick < 6) begin
            emit(TICK_PRESENT, hold_span(cfg_start) + $urandom_range(0, 20), s.quota);
            emit(TICK_ABSENT, hold_span(cfg_end) + $urandom_range(0, 5), s.quota);
         end else if (pick < 8) begin
            emit(TICK_ABSENT, $urandom_range(1, 10), s.quota);
         end else if (pick < 9) begin
            emit(TICK_NOISE, $urandom_range(1, 5), s.quota);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               emit(TICK_PRESENT, 1, s.quota);
               emit(TICK_ABSENT, 1, s.quota);
            end
         end
      end
   endtask

   task automatic check_response(gdc_rsp_type got);
      gdc_rsp_type want;
      if (dimmer_outputs_due.size() == 0) begin
         record_fault($sformatf("unrequested output: pw %0d chg %0b dly %0d lamp %0b trk %0b",
            got.pulse_width, got.duty_changed, got.step_delay, got.lamp_on,
            got.tracking_mode));
         return;
      end
      want = dimmer_outputs_due.pop_front();
      outputs_checked++;
      if (got.pulse_width !== want.pulse_width || got.duty_changed !== want.duty_changed ||
          got.step_delay !== want.step_delay || got.lamp_on !== want.lamp_on ||
          got.tracking_mode !== want.tracking_mode) begin
         record_fault($sformatf({"output %0d: pw exp %0d got %0d, chg exp %0b got %0b, ",
            "dly exp %0d got %0d, lamp exp %0b got %0b, trk exp %0b got %0b"},
            outputs_checked, want.pulse_width, got.pulse_width, want.duty_changed,
            got.duty_changed, want.step_delay, got.step_delay, want.lamp_on, got.lamp_on,
            want.tracking_mode, got.tracking_mode));
      end
   endtask

   // output side: random stall before each output, sometimes none for a while
   initial begin
      int unsigned stall_cycles;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) drain_eager = !drain_eager;
         stall_cycles = drain_eager ? 0 : $urandom_range(0, 8);
         if (stall_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         check_response(rsp_data);
         @(negedge clock);
      end
   end

   // watchdog: too long without any request or output moving
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      fault_count = 0;
      requests_sent = 0;
      outputs_checked = 0;
      settings_used = 1;
      feed_eager = 1'b0;
      drain_eager = 1'b0;
      dimmer_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed ticks
      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].reconfig) settle_then_apply(DIRECTED_SETUP);
         push_request(DIRECTED_PLAN[i].req, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].rsp);
      end

      // random gesture traffic under each setting; spare addresses must be ignored
      foreach (RANDOM_PHASES[p]) begin
         settle_then_apply(RANDOM_PHASES[p]);
         if (p == 4) begin
            write_register(REG_SPARE_LO, $urandom());
            write_register(REG_SPARE_HI, $urandom());
         end
         play_gestures(RANDOM_PHASES[p]);
      end

      req_valid <= 1'b0;
      while (dimmer_outputs_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d sensor ticks under %0d register settings; %0d outputs compared.",
         requests_sent, settings_used, outputs_checked);
      $display("Traffic held taps, tracking holds, hold-counter wraps and noise; %0d faults.",
         fault_count);
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
